### rtl/scm_pkg.sv
// Shared types and codes for the stack calculator: opcodes, status codes,
// channel items, the decoded command word and the back-end states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package scm_pkg;

    localparam int DATA_W      = 32;
    localparam int SLOT_W      = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_CNT_W   = 6;

    typedef enum logic [2:0] {
        OP_PUSH_IMM = 3'd0,
        OP_PUSH_VAR = 3'd1,
        OP_POP_VAR  = 3'd2,
        OP_ADD      = 3'd3,
        OP_SUB      = 3'd4,
        OP_MUL      = 3'd5,
        OP_DIV      = 3'd6,
        OP_PRINT    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_FEW     = 3'd2,
        STAT_DIVZERO = 3'd3,
        STAT_UNSET   = 3'd4,
        STAT_FULL    = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CL_PUSH_IMM,
        CL_PUSH_VAR,
        CL_POP_VAR,
        CL_PRINT,
        CL_ALU
    } cmd_class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VAR_RD,
        S_POP,
        S_READ_X,
        S_READ_Y,
        S_DIV,
        S_WB
    } exec_state_t;

    typedef struct packed {
        logic [2:0]               op;
        logic signed [DATA_W-1:0] immediate;
        logic [SLOT_W-1:0]        var_slot;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
    } rsp_item_t;

    // decoded instruction as it sits in the queue
    typedef struct packed {
        cmd_class_t        cls;
        op_t               alu_op;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] imm;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/scm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/scm_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_div import scm_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W);
            rem_next  = '0;
            // magnitudes; the most negative value maps onto itself as unsigned
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

`default_nettype wire

### rtl/scm_front.sv
// Front end: takes instruction items, classifies them and holds one decoded
// command for the queue. Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_front import scm_pkg::*; #(
    parameter int VAR_SLOTS = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd,
    output logic           q_wr,
    output cmd_t           q_data,
    input  wire logic      q_full
);

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_reg, hold_next;
    cmd_t decoded;
    logic take;

    always_comb
    begin
        decoded.alu_op  = op_t'(cmd.op);
        decoded.slot    = cmd.var_slot;
        decoded.imm     = cmd.immediate;
        decoded.slot_ok = (32'(cmd.var_slot) < 32'(VAR_SLOTS));
        case (cmd.op)
            OP_PUSH_IMM: decoded.cls = CL_PUSH_IMM;
            OP_PUSH_VAR: decoded.cls = CL_PUSH_VAR;
            OP_POP_VAR:  decoded.cls = CL_POP_VAR;
            OP_PRINT:    decoded.cls = CL_PRINT;
            default:     decoded.cls = CL_ALU;
        endcase
    end

    assign cmd_stall = hold_valid_reg && q_full;
    assign take      = cmd_valid && !cmd_stall;
    assign q_wr      = hold_valid_reg;
    assign q_data    = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
            hold_next       = decoded;
        end
        else if (hold_valid_reg && !q_full)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

### rtl/scm_queue.sv
// Short FIFO of decoded commands between front and back end.
// Depends on scm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scm_queue import scm_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;
    logic          do_wr, do_rd;

    assign full    = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/scm_exec.sv
// Back end: executes decoded commands on the operand stack RAM and the
// variable RAM, owns the divider and the result register.
// Depends on scm_pkg, scm_ram, scm_div.
`timescale 1ns / 1ps
`default_nettype none

module scm_exec import scm_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_SLOTS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic q_empty,
    output logic      q_rd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_item_t rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int VW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

    exec_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [VAR_SLOTS-1:0] var_valid_reg, var_valid_next;
    logic [DATA_W-1:0]    x_reg, x_next;
    logic [DATA_W-1:0]    r_reg, r_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_item_t            rsp_reg, rsp_next;

    logic [CW-1:0]        count_m1, count_m2;
    logic                 stack_full;
    logic                 out_free;
    logic                 res_fire;
    rsp_item_t            res;

    logic [VW+SLOT_W-1:0] head_slot_ext, cmd_slot_ext;
    logic [VW-1:0]        head_vidx, cmd_vidx;

    logic                 st_we;
    logic [AW-1:0]        st_waddr, st_raddr;
    logic [DATA_W-1:0]    st_wdata, st_rdata;
    logic                 var_we;
    logic [VW-1:0]        var_waddr, var_raddr;
    logic [DATA_W-1:0]    var_wdata, var_rdata;

    logic                 div_start, div_done;
    logic [DATA_W-1:0]    div_q;

    scm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    scm_ram #(.WIDTH(DATA_W), .DEPTH(VAR_SLOTS)) u_var_ram (
        .clk   (clk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    scm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (x_reg),
        .divisor  (st_rdata),
        .done     (div_done),
        .quotient (div_q)
    );

    assign count_m1      = count_reg - 1'b1;
    assign count_m2      = count_reg - CW'(2);
    assign stack_full    = (count_reg == CW'(STACK_DEPTH));
    assign out_free      = !rsp_valid_reg || !rsp_stall;
    assign head_slot_ext = {{VW{1'b0}}, head.slot};
    assign cmd_slot_ext  = {{VW{1'b0}}, cmd_reg.slot};
    assign head_vidx     = head_slot_ext[VW-1:0];
    assign cmd_vidx      = cmd_slot_ext[VW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        var_valid_next = var_valid_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        q_rd           = 1'b0;
        st_we          = 1'b0;
        st_waddr       = count_reg[AW-1:0];
        st_wdata       = r_reg;
        st_raddr       = count_m1[AW-1:0];
        var_we         = 1'b0;
        var_waddr      = cmd_vidx;
        var_wdata      = st_rdata;
        var_raddr      = head_vidx;
        div_start      = 1'b0;
        res_fire       = 1'b0;
        res.status      = STAT_OK;
        res.print_valid = 1'b0;
        res.print_value = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_rd     = 1'b1;
                    cmd_next = head;
                    case (head.cls)
                        CL_PUSH_IMM:
                        begin
                            res_fire = 1'b1;
                            if (stack_full)
                            begin
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                st_we      = 1'b1;
                                st_wdata   = head.imm;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CL_PUSH_VAR:
                        begin
                            if (!(head.slot_ok && var_valid_reg[head_vidx]))
                            begin
                                res_fire   = 1'b1;
                                res.status = STAT_UNSET;
                            end
                            else if (stack_full)
                            begin
                                res_fire   = 1'b1;
                                res.status = STAT_FULL;
                            end
                            else
                            begin
                                state_next = S_VAR_RD;
                            end
                        end
                        CL_POP_VAR, CL_PRINT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_fire   = 1'b1;
                                res.status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        default:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                res_fire   = 1'b1;
                                res.status = STAT_FEW;
                            end
                            else
                            begin
                                state_next = S_READ_X;
                            end
                        end
                    endcase
                end
            end
            S_VAR_RD:
            begin
                st_we      = 1'b1;
                st_wdata   = var_rdata;
                count_next = count_reg + 1'b1;
                res_fire   = 1'b1;
                state_next = S_IDLE;
            end
            S_POP:
            begin
                if (cmd_reg.cls == CL_PRINT)
                begin
                    res.print_valid = 1'b1;
                    res.print_value = st_rdata;
                end
                else if (cmd_reg.slot_ok)
                begin
                    var_we                   = 1'b1;
                    var_valid_next[cmd_vidx] = 1'b1;
                end
                count_next = count_m1;
                res_fire   = 1'b1;
                state_next = S_IDLE;
            end
            S_READ_X:
            begin
                x_next     = st_rdata;
                st_raddr   = count_m2[AW-1:0];
                state_next = S_READ_Y;
            end
            S_READ_Y:
            begin
                // x is the old top, the RAM now returns y
                if (cmd_reg.alu_op == OP_DIV)
                begin
                    if (st_rdata == '0)
                    begin
                        res_fire   = 1'b1;
                        res.status = STAT_DIVZERO;
                        count_next = count_m2;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    case (cmd_reg.alu_op)
                        OP_ADD:  r_next = x_reg + st_rdata;
                        OP_SUB:  r_next = x_reg - st_rdata;
                        default: r_next = x_reg * st_rdata;
                    endcase
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    r_next     = div_q;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                st_we      = 1'b1;
                st_waddr   = count_m2[AW-1:0];
                st_wdata   = r_reg;
                count_next = count_m1;
                res_fire   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (res_fire)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            var_valid_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            var_valid_reg <= var_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        x_reg   <= x_next;
        r_reg   <= r_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> out_free)
        else $error("result overwrites an undelivered item");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (st_rdata != '0))
        else $error("divider started with zero divisor");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !div_done) |=> (state_reg == S_DIV))
        else $error("left divide wait before quotient was ready");

    a_print_src: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.print_valid) |-> (state_reg == S_POP && cmd_reg.cls == CL_PRINT))
        else $error("print value produced outside a print");

endmodule

`default_nettype wire

### rtl/stack_calculator_with_variables_core.sv
// Top level of the stack calculator: front end, command queue, back end.
// Depends on scm_pkg, scm_front, scm_queue, scm_exec (scm_ram, scm_div).
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid/cmd_stall  | cmd_item_t: op, immediate, var_slot
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_item_t: status, print_valid, print_value
//
// One item in flight in the back end; front end and queue take items until the queue fills.
// Push immediate and dispatch errors end in S_IDLE; push variable adds S_VAR_RD, pop and
// print S_POP, add/sub/mul S_READ_X, S_READ_Y, S_WB; divide also waits in S_DIV (32 quotient
// bits, one per cycle in the divider). Items pass the front register and a queue entry
// before dispatch. Reset clears stack count, variable valid bits and handshake state;
// stack and variable RAM contents are left as is. A stalled result holds the back end only.
`timescale 1ns / 1ps
`default_nettype none

module stack_calculator_with_variables_core import scm_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VAR_SLOTS   = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_stall,
    input  wire cmd_item_t cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    logic q_wr, q_full, q_rd, q_empty;
    cmd_t q_wdata, q_head;

    scm_front #(.VAR_SLOTS(VAR_SLOTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_wr      (q_wr),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    scm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    scm_exec #(.STACK_DEPTH(STACK_DEPTH), .VAR_SLOTS(VAR_SLOTS)) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
